[rtl/twspq_pkg.sv]
`default_nettype none
package twspq_pkg;

  localparam int QUEUE_DEPTH   = 256;
  localparam int PRIORITY_BITS = 4;
  localparam int NUM_QUEUES    = 3;
  localparam int TICKET_BITS   = 16;
  localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_SERVED = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef struct packed {
    logic       cmd;
    logic [1:0] queue_sel;
    logic [3:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] ticket;
    logic [1:0]  queue_id;
  } rsp_t;

  typedef struct packed {
    logic [PRIORITY_BITS-1:0] prio;
    logic [TICKET_BITS-1:0]   ticket;
  } entry_t;

  // broadcast to every cell of one chain
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } cell_op_t;

endpackage
`default_nettype wire

[rtl/twspq_cell.sv]
`default_nettype none
module twspq_cell (
  input  wire                    clk,
  input  twspq_pkg::cell_op_t    op,
  input  wire                    valid,
  input  wire                    left_place,
  input  twspq_pkg::entry_t      left_entry,
  input  twspq_pkg::entry_t      right_entry,
  output logic                   place,
  output twspq_pkg::entry_t      entry
);

  twspq_pkg::entry_t entry_next;

  // new entry goes ahead of this one only on a strictly higher priority,
  // so equal priorities keep arrival order
  assign place = !valid || (op.new_entry.prio > entry.prio);

  always_comb begin
    entry_next = entry;
    if (op.rem) begin
      entry_next = right_entry;
    end else if (op.ins && place) begin
      entry_next = left_place ? left_entry : op.new_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

[rtl/twspq_chain.sv]
`default_nettype none
module twspq_chain (
  input  wire                                  clk,
  input  wire                                  rst,
  input  twspq_pkg::cell_op_t                  op,
  output twspq_pkg::entry_t                    head,
  output logic [twspq_pkg::COUNT_BITS-1:0]     count
);

  twspq_pkg::entry_t                   cell_entry [twspq_pkg::QUEUE_DEPTH];
  logic [twspq_pkg::QUEUE_DEPTH-1:0]   cell_place;
  logic [twspq_pkg::COUNT_BITS-1:0]    count_next;

  genvar i;
  generate
    for (i = 0; i < twspq_pkg::QUEUE_DEPTH; i++) begin : g_cell
      twspq_pkg::entry_t left_e;
      twspq_pkg::entry_t right_e;
      logic              left_p;
      logic              cell_valid;

      assign cell_valid = twspq_pkg::COUNT_BITS'(i) < count;

      if (i == 0) begin : g_first
        assign left_p = 1'b0;
        assign left_e = op.new_entry;
      end else begin : g_mid
        assign left_p = cell_place[i-1];
        assign left_e = cell_entry[i-1];
      end

      if (i == twspq_pkg::QUEUE_DEPTH - 1) begin : g_last
        assign right_e = cell_entry[i];
      end else begin : g_inner
        assign right_e = cell_entry[i+1];
      end

      twspq_cell u_cell (
        .clk         (clk),
        .op          (op),
        .valid       (cell_valid),
        .left_place  (left_p),
        .left_entry  (left_e),
        .right_entry (right_e),
        .place       (cell_place[i]),
        .entry       (cell_entry[i])
      );
    end
  endgenerate

  assign head = cell_entry[0];

  always_comb begin
    count_next = count;
    if (op.ins) begin
      count_next = count + 1'b1;
    end else if (op.rem) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

[rtl/three_way_stable_priority_queue_unit.sv]
`default_nettype none
// Channel | Signals                      | Payload
// --------+------------------------------+------------------------------------
// request | req_valid, req_stall, req    | cmd, queue_sel, priority_req
// result  | rsp_valid, rsp_stall, rsp    | status, ticket, queue_id
//
// One request per cycle unless req_stall: each queue is a sorted chain of
// cells, best entry at the head, which absorbs one insert or remove per clock.
// A result appears in the output register the cycle after its transfer.
// Reset clears the fill counts and sets the ticket counter to one.
// req_stall is high only while a held result is stalled.
module three_way_stable_priority_queue_unit (
  input  wire               clk,
  input  wire               rst,
  input  wire               req_valid,
  output logic              req_stall,
  input  twspq_pkg::req_t   req,
  output logic              rsp_valid,
  input  wire               rsp_stall,
  output twspq_pkg::rsp_t   rsp
);

  twspq_pkg::cell_op_t                  op    [twspq_pkg::NUM_QUEUES];
  twspq_pkg::entry_t                    head  [twspq_pkg::NUM_QUEUES];
  logic [twspq_pkg::COUNT_BITS-1:0]     count [twspq_pkg::NUM_QUEUES];

  logic [twspq_pkg::TICKET_BITS-1:0]    next_ticket;
  logic [1:0]                           q;
  logic                                 accept;
  logic                                 is_ins;
  logic                                 full;
  logic                                 empty;
  logic                                 ins_ok;
  logic                                 rem_ok;
  twspq_pkg::entry_t                    new_entry;
  twspq_pkg::rsp_t                      rsp_next;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign q         = (req.queue_sel == 2'd3) ? 2'd2 : req.queue_sel;
  assign is_ins    = (req.cmd == twspq_pkg::CMD_INSERT);
  assign full      = (count[q] == twspq_pkg::COUNT_BITS'(twspq_pkg::QUEUE_DEPTH));
  assign empty     = (count[q] == '0);
  assign ins_ok    = accept && is_ins && !full && (next_ticket != '0);
  assign rem_ok    = accept && !is_ins && !empty;

  assign new_entry.prio   = twspq_pkg::PRIORITY_BITS'(req.priority_req);
  assign new_entry.ticket = next_ticket;

  genvar g;
  generate
    for (g = 0; g < twspq_pkg::NUM_QUEUES; g++) begin : g_queue
      assign op[g].ins       = ins_ok && (q == 2'(g));
      assign op[g].rem       = rem_ok && (q == 2'(g));
      assign op[g].new_entry = new_entry;

      twspq_chain u_chain (
        .clk   (clk),
        .rst   (rst),
        .op    (op[g]),
        .head  (head[g]),
        .count (count[g])
      );
    end
  endgenerate

  always_comb begin
    rsp_next.queue_id = q;
    rsp_next.ticket   = '0;
    if (is_ins) begin
      rsp_next.status = twspq_pkg::ST_FULL;
    end else if (empty) begin
      rsp_next.status = twspq_pkg::ST_EMPTY;
    end else begin
      rsp_next.status = twspq_pkg::ST_SERVED;
      rsp_next.ticket = head[q].ticket;
    end
  end

  // ticket counter wraps to zero after the last ticket, which blocks inserts
  always_ff @(posedge clk) begin
    if (rst) begin
      next_ticket <= twspq_pkg::TICKET_BITS'(1);
    end else if (ins_ok) begin
      next_ticket <= next_ticket + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept && !ins_ok) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !ins_ok) begin
      rsp <= rsp_next;
    end
  end

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;

  localparam int IDLE_PCT      = 11;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam int REPORT_LIMIT  = 10;
  localparam int MIX_ITEMS     = 210;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  twspq_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  twspq_pkg::rsp_t rsp;

  // idling switched off for a stretch; receiver hold-off request
  logic calm = 1'b0;
  logic hold_wanted = 1'b0;
  int hold_left = 0;
  int error_count = 0;
  int quiet_cycles = 0;

  // mirror of the three queues
  twspq_pkg::entry_t held [twspq_pkg::NUM_QUEUES][twspq_pkg::QUEUE_DEPTH];
  int fill [twspq_pkg::NUM_QUEUES];
  logic [twspq_pkg::TICKET_BITS-1:0] ticket_next;
  twspq_pkg::rsp_t results_due [$];

  three_way_stable_priority_queue_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #10 clk = ~clk;

  // Works out the result of one request and updates the mirror.
  // Returns 1 when the request yields a result.
  function automatic bit predict_service(input twspq_pkg::req_t r,
                                         output twspq_pkg::rsp_t res);
    int q;
    int n;
    int best;
    q = (r.queue_sel > 2'd2) ? 2 : int'(r.queue_sel);
    n = fill[q];
    res = '0;
    res.queue_id = 2'(q);
    if (r.cmd == twspq_pkg::CMD_INSERT) begin
      if (n >= twspq_pkg::QUEUE_DEPTH || ticket_next == '0) begin
        res.status = twspq_pkg::ST_FULL;
        return 1'b1;
      end
      held[q][n].prio = r.priority_req[twspq_pkg::PRIORITY_BITS-1:0];
      held[q][n].ticket = ticket_next;
      fill[q] = n + 1;
      ticket_next = ticket_next + 1'b1;   // wraps to zero once exhausted
      return 1'b0;
    end
    if (n == 0) begin
      res.status = twspq_pkg::ST_EMPTY;
      return 1'b1;
    end
    best = 0;
    for (int i = 1; i < n; i++) begin
      if (held[q][i].prio > held[q][best].prio ||
          (held[q][i].prio == held[q][best].prio &&
           held[q][i].ticket < held[q][best].ticket))
        best = i;
    end
    res.status = twspq_pkg::ST_SERVED;
    res.ticket = held[q][best].ticket;
    held[q][best] = held[q][n-1];
    fill[q] = n - 1;
    return 1'b1;
  endfunction

  task automatic report_fault(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT)
      $display("%0t: %s", $realtime, msg);
  endtask

  task automatic send_request(input twspq_pkg::cmd_t op, input logic [1:0] sel,
                              input logic [3:0] prio);
    twspq_pkg::req_t item;
    twspq_pkg::rsp_t res;
    item.cmd = op;
    item.queue_sel = sel;
    item.priority_req = prio;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (predict_service(item, res)) results_due.push_back(res);
    @(negedge clk);
  endtask

  // sender pause: nothing offered until every result is back
  task automatic wait_results();
    req_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off when asked
  always @(negedge clk) begin
    if (hold_wanted) begin
      hold_left = HOLD_CYCLES;
      hold_wanted = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    twspq_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (results_due.size() == 0) begin
        report_fault($sformatf("unexpected result: status %0d ticket %0d queue %0d",
                               rsp.status, rsp.ticket, rsp.queue_id));
      end else begin
        want = results_due.pop_front();
        if (rsp.status !== want.status || rsp.ticket !== want.ticket ||
            rsp.queue_id !== want.queue_id)
          report_fault($sformatf(
            "mismatch: expected status %0d ticket %0d queue %0d, got %0d %0d %0d",
            want.status, want.ticket, want.queue_id,
            rsp.status, rsp.ticket, rsp.queue_id));
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic test_directed_cases();
    // removes on empty queues, selector three folds onto queue 2
    send_request(twspq_pkg::CMD_REMOVE, 2'd0, 4'h0);
    send_request(twspq_pkg::CMD_REMOVE, 2'd1, 4'hF);
    send_request(twspq_pkg::CMD_REMOVE, 2'd2, 4'h5);
    send_request(twspq_pkg::CMD_REMOVE, 2'd3, 4'hA);
    send_request(twspq_pkg::CMD_INSERT, 2'd0, 4'h0);
    send_request(twspq_pkg::CMD_INSERT, 2'd0, 4'hF);
    send_request(twspq_pkg::CMD_INSERT, 2'd0, 4'hF);
    send_request(twspq_pkg::CMD_INSERT, 2'd0, 4'h7);
    send_request(twspq_pkg::CMD_INSERT, 2'd1, 4'h5);
    send_request(twspq_pkg::CMD_INSERT, 2'd1, 4'h5);
    send_request(twspq_pkg::CMD_INSERT, 2'd3, 4'hF);
    // equal priorities leave in arrival order
    send_request(twspq_pkg::CMD_REMOVE, 2'd0, 4'h0);
    send_request(twspq_pkg::CMD_REMOVE, 2'd0, 4'hF);
    send_request(twspq_pkg::CMD_REMOVE, 2'd0, 4'h0);
    send_request(twspq_pkg::CMD_REMOVE, 2'd0, 4'h0);
    send_request(twspq_pkg::CMD_REMOVE, 2'd0, 4'h0);
    send_request(twspq_pkg::CMD_REMOVE, 2'd1, 4'h0);
    send_request(twspq_pkg::CMD_REMOVE, 2'd1, 4'h0);
    send_request(twspq_pkg::CMD_REMOVE, 2'd3, 4'h0);
    send_request(twspq_pkg::CMD_REMOVE, 2'd2, 4'h0);
    wait_results();
  endtask

  task automatic test_random_mix();
    int ins_pct;
    logic [3:0] p;
    for (int phase = 0; phase < 6; phase++) begin
      calm = (phase == 3);
      ins_pct = (phase % 3 == 0) ? 70 : ((phase % 3 == 1) ? 35 : 55);
      for (int k = 0; k < MIX_ITEMS; k++) begin
        // one phase crowds the priorities together to force ties
        p = (phase == 2) ? ($urandom_range(1) ? 4'hF : 4'h0) : 4'($urandom_range(15));
        send_request(($urandom_range(99) < ins_pct) ? twspq_pkg::CMD_INSERT
                                                    : twspq_pkg::CMD_REMOVE,
                     2'($urandom_range(3)), p);
      end
    end
    calm = 1'b0;
    wait_results();
  endtask

  task automatic test_queue_full();
    while (fill[1] < twspq_pkg::QUEUE_DEPTH)
      send_request(twspq_pkg::CMD_INSERT, 2'd1, 4'($urandom_range(15)));
    send_request(twspq_pkg::CMD_INSERT, 2'd1, 4'hA);
    send_request(twspq_pkg::CMD_INSERT, 2'd0, 4'h3);
    wait_results();
    // drain against a stalled receiver so the block backs up
    hold_wanted = 1'b1;
    while (fill[1] > 0)
      send_request(twspq_pkg::CMD_REMOVE, 2'd1, 4'($urandom_range(15)));
    send_request(twspq_pkg::CMD_REMOVE, 2'd1, 4'h0);
    wait_results();
  endtask

  task automatic test_drain_all();
    // empty every queue, then a remove on the empty queue and a fresh insert
    for (int s = 0; s < twspq_pkg::NUM_QUEUES; s++) begin
      while (fill[s] > 0)
        send_request(twspq_pkg::CMD_REMOVE, 2'(s), 4'($urandom_range(15)));
      send_request(twspq_pkg::CMD_REMOVE, 2'(s), 4'h0);
      send_request(twspq_pkg::CMD_INSERT, 2'(s), 4'hF);
    end
    wait_results();
  endtask

  initial begin
    ticket_next = 1;
    for (int s = 0; s < twspq_pkg::NUM_QUEUES; s++) fill[s] = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_cases();
    test_random_mix();
    test_queue_full();
    test_drain_all();
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/twspq_pkg.sv
rtl/twspq_cell.sv
rtl/twspq_chain.sv
rtl/three_way_stable_priority_queue_unit.sv
tb/testbench.sv
